/* design/quoted_command_tokenizer_top_assert.svh */
// assertion macros for the quoted command tokenizer
// expects clk and arst_n in the scope of the module that includes it
`ifndef QUOTED_COMMAND_TOKENIZER_TOP_ASSERT_SVH
`define QUOTED_COMMAND_TOKENIZER_TOP_ASSERT_SVH

// checked only while out of reset
`define QCT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("qct assertion failed");

// checked during reset too
`define QCT_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("qct assertion failed");

`endif

/* design/qct_pkg.sv */
// types and constants shared by the quoted command tokenizer modules
// no dependencies
package qct_pkg;

	localparam int unsigned CHAR_W = 8;
	localparam int unsigned MAX_RES = 3;

	// character codes
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
	localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;

	// open quote kinds
	localparam logic [1:0] QK_NONE   = 2'd0;
	localparam logic [1:0] QK_DOUBLE = 2'd1;
	localparam logic [1:0] QK_SINGLE = 2'd2;

	// configuration register indexes
	localparam logic CFG_SEPARATOR  = 1'b0;
	localparam logic CFG_TERMINATOR = 1'b1;

	typedef struct packed {
		logic [1:0] open_quote;
		logic       awaiting;
		logic       skipping;
	} qct_state_t;

	// up to three characters made by one input beat
	typedef struct packed {
		logic [1:0]                     cnt;
		logic [MAX_RES-1:0][CHAR_W-1:0] chars;
		logic                           last;
	} qct_res_t;

	typedef struct packed {
		logic free;
		logic busy;
	} qct_buf_status_t;

endpackage

/* design/quoted_command_tokenizer_top.sv */
// Quoted command tokenizer: takes one command character per beat and emits the
// token stream (separators for blank runs and closing quotes, quoted text kept
// verbatim, empty quote pairs literal, terminator flagged last at the end).
// Throughput is one character per cycle when out_stall is low and a character
// yields at most one output beat; a character with two or three beats holds
// in_stall while the three-entry result register drains one beat per cycle
// with out_stall low. Beats pass the input register, then the result register.
// Configuration writes are always ready and must only happen while idle.
// Depends on qct_pkg, qct_step, qct_outbuf and the assertion header.
module quoted_command_tokenizer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_char,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       out_last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);
	import qct_pkg::*;

	logic            valid_s1;
	logic [7:0]      char_s1;
	logic            last_s1;
	logic [7:0]      separator_q;
	logic [7:0]      terminator_q;
	qct_state_t      state_q;
	qct_state_t      next_state;
	qct_res_t        res;
	qct_buf_status_t buf_status;
	logic            advance;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			separator_q <= '0;
			terminator_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SEPARATOR: separator_q <= cfg_data;
				CFG_TERMINATOR: terminator_q <= cfg_data;
				default: separator_q <= separator_q;
			endcase
		end
	end

	// an item with no output beat never waits for the result register
	assign advance = valid_s1 && ((res.cnt == 2'd0) || buf_status.free);
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			char_s1 <= in_char;
			last_s1 <= in_last;
		end
	end

	// tokenizer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= next_state;
		end
	end

	qct_step u_step (
		.in_char         (char_s1),
		.in_last         (last_s1),
		.separator_char  (separator_q),
		.terminator_char (terminator_q),
		.state           (state_q),
		.next_state      (next_state),
		.res             (res)
	);

	qct_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && (res.cnt != 2'd0)),
		.load_res  (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_char  (out_char),
		.out_last  (out_last),
		.status    (buf_status)
	);

	// checks
	`include "quoted_command_tokenizer_top_assert.svh"

	`QCT_ASSERT_ALWAYS(a_stall_needs_item, in_stall |-> valid_s1)
	`QCT_ASSERT(a_last_clears_state, (advance && last_s1) |=> (state_q == '0))
	`QCT_ASSERT(a_empty_buf_is_free, (!buf_status.busy) |-> buf_status.free)

endmodule

/* design/qct_step.sv */
// next-state and result logic for one command character
// depends on qct_pkg
module qct_step (
	input  logic [7:0]          in_char,
	input  logic                in_last,
	input  logic [7:0]          separator_char,
	input  logic [7:0]          terminator_char,
	input  qct_pkg::qct_state_t state,
	output qct_pkg::qct_state_t next_state,
	output qct_pkg::qct_res_t   res
);
	import qct_pkg::*;

	logic [CHAR_W-1:0] c;
	logic [1:0]        kind;
	logic              blank;
	logic [1:0]        n;
	qct_state_t        ns;

	// terminator counts as a space
	assign c = (in_char == terminator_char) ? CH_SPACE : in_char;
	assign blank = ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);

	always_comb begin
		if (c == CH_DQUOTE) begin
			kind = QK_DOUBLE;
		end else if (c == CH_SQUOTE) begin
			kind = QK_SINGLE;
		end else begin
			kind = QK_NONE;
		end
	end

	// main character decision
	always_comb begin
		ns = state;
		n = 2'd0;
		res.chars = '0;
		res.last = in_last;
		if (state.awaiting) begin
			ns.awaiting = 1'b0;
			if ((state.open_quote != QK_NONE) && (kind == state.open_quote)) begin
				// empty quote pair passes through literally
				res.chars[0] = c;
				res.chars[1] = c;
				n = 2'd2;
				ns.open_quote = QK_NONE;
			end else begin
				if (state.open_quote == QK_NONE) begin
					ns.open_quote = QK_DOUBLE;
				end
				res.chars[0] = c;
				n = 2'd1;
			end
		end else if (state.open_quote != QK_NONE) begin
			if (kind == state.open_quote) begin
				res.chars[0] = separator_char;
				n = 2'd1;
				ns.open_quote = QK_NONE;
				ns.skipping = 1'b1;
			end else begin
				res.chars[0] = c;
				n = 2'd1;
			end
		end else if (kind != QK_NONE) begin
			ns.open_quote = kind;
			ns.awaiting = 1'b1;
			ns.skipping = 1'b0;
		end else if (blank) begin
			if (!state.skipping) begin
				res.chars[0] = separator_char;
				n = 2'd1;
				ns.skipping = 1'b1;
			end
		end else begin
			res.chars[0] = c;
			n = 2'd1;
			ns.skipping = 1'b0;
		end

		// end of command appends the terminator and clears state
		if (in_last) begin
			case (n)
				2'd0: res.chars[0] = terminator_char;
				2'd1: res.chars[1] = terminator_char;
				2'd2: res.chars[2] = terminator_char;
				default: res.chars[0] = terminator_char;
			endcase
			n = n + 2'd1;
			ns = '0;
		end
		res.cnt = n;
		next_state = ns;
	end

endmodule

/* design/qct_outbuf.sv */
// result register holding up to three characters, drained one beat a cycle while out_stall is low
// depends on qct_pkg
module qct_outbuf (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  qct_pkg::qct_res_t        load_res,
	input  logic                     out_stall,
	output logic                     out_valid,
	output logic [7:0]               out_char,
	output logic                     out_last,
	output qct_pkg::qct_buf_status_t status
);
	import qct_pkg::*;

	logic [1:0]                     cnt_q;
	logic [1:0]                     idx_q;
	logic [MAX_RES-1:0][CHAR_W-1:0] chars_q;
	logic                           last_q;
	logic                           pop;
	logic                           final_pos;

	assign out_valid = (cnt_q != 2'd0);
	assign pop = out_valid && !out_stall;
	assign final_pos = (idx_q == (cnt_q - 2'd1));

	// buffer can take a new item once its last beat leaves
	assign status.free = (cnt_q == 2'd0) || (pop && final_pos);
	assign status.busy = out_valid;

	// count and read index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (load) begin
			cnt_q <= load_res.cnt;
			idx_q <= 2'd0;
		end else if (pop) begin
			if (final_pos) begin
				cnt_q <= 2'd0;
				idx_q <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			chars_q <= load_res.chars;
			last_q <= load_res.last;
		end
	end

	always_comb begin
		case (idx_q)
			2'd0: out_char = chars_q[0];
			2'd1: out_char = chars_q[1];
			2'd2: out_char = chars_q[2];
			default: out_char = chars_q[0];
		endcase
	end

	assign out_last = last_q && final_pos;

endmodule
